FILE: hdl/assert_macros.svh
// Assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_CLK_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_CLK_NR(lbl, clk, prop, msg)
`endif
`endif

FILE: hdl/pts_pkg.sv
// Package: constants and types of the process tree size table.
package pts_pkg;
    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int MAX_CHAIN_DEF = 64;
    localparam int ID_W = 23;
    localparam int PAGES_W = 28;
    localparam int PSIZE_W = 17;
    localparam int AMT_W = 55;
    localparam logic [PSIZE_W-1:0] PSIZE_RESET = 17'd4096;
    localparam logic [AMT_W-1:0] AMT_MAX = {AMT_W{1'b1}};

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0, CMD_ADD = 2'd1, CMD_OWN = 2'd2, CMD_TREE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0, ST_FULL = 2'd1, ST_MISS = 2'd2, ST_BADID = 2'd3
    } status_t;
endpackage

FILE: hdl/pts_ram.sv
// Generic single-port-write, single-read RAM with registered read.
module pts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: hdl/process_tree_size_table.sv
// Top level: process tree size table with sorted entry memory.
//
// channel  | dir | fields (low bit first)
// s_axis   | in  | tdata: command[1:0] process_id[24:2] parent_id[47:25] size_pages[75:48]
// m_axis   | out | tdata: amount_bytes[54:0] status[56:55]
// cfg      | in  | cfg_data: page_size_bytes
//
// Clear goes straight to the result; own-size query: search, read, multiply.
// Add: search; update if found, else shift later entries up (one read, one write each).
// Tree query: per table entry, up to MAX_CHAIN binary searches of the id
// memory; rate is set by the single read port of the id memory.
// Reset clears the entry count; memories need no clearing pass.
// A stalled result holds in m_tdata; no word is accepted until it is taken.
module process_tree_size_table #(
    parameter int TABLE_DEPTH = pts_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_CHAIN = pts_pkg::MAX_CHAIN_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [79:0]                 s_tdata,  // command, process_id, parent_id, size_pages
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [63:0]                 m_tdata,  // amount_bytes, status
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [pts_pkg::PSIZE_W-1:0] cfg_data
);
    import pts_pkg::*;
`include "assert_macros.svh"

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int DW = $clog2(MAX_CHAIN + 1);

    typedef enum logic [14:0] {
        S_IDLE   = 15'b000000000000001,
        S_SRD    = 15'b000000000000010,
        S_SCMP   = 15'b000000000000100,
        S_DECIDE = 15'b000000000001000,
        S_SHRD   = 15'b000000000010000,
        S_SHWR   = 15'b000000000100000,
        S_INS    = 15'b000000001000000,
        S_OWNRD  = 15'b000000010000000,
        S_MUL    = 15'b000000100000000,
        S_TENT   = 15'b000001000000000,
        S_TCHK   = 15'b000010000000000,
        S_TPAR   = 15'b000100000000000,
        S_TADD   = 15'b001000000000000,
        S_TSUM   = 15'b010000000000000,
        S_OUT    = 15'b100000000000000
    } state_t;

    // search purposes
    typedef enum logic [1:0] {
        P_ADD = 2'd0, P_QRY = 2'd1, P_WALK = 2'd2
    } purpose_t;

    state_t state_reg, state_next;
    purpose_t purp_reg, purp_next;
    logic [PSIZE_W-1:0] psize_reg;
    logic [CW-1:0] count_reg, count_next;
    cmd_t cmd_reg, cmd_next;
    logic [ID_W-1:0] id_reg, id_next, par_reg, par_next;
    logic [PAGES_W-1:0] pg_reg, pg_next;
    logic [CW-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [ID_W-1:0] key_reg, key_next;
    logic found_reg, found_next;
    logic [AW-1:0] fidx_reg, fidx_next;
    logic [CW-1:0] sh_reg, sh_next;
    logic [CW-1:0] ent_reg, ent_next;
    logic [AW-1:0] eidx_reg, eidx_next;
    logic [ID_W-1:0] cur_reg, cur_next;
    logic [DW-1:0] dep_reg, dep_next;
    logic [AMT_W-1:0] tot_reg, tot_next;
    logic [AMT_W:0] prod_reg, prod_next;
    logic [AMT_W-1:0] amt_reg, amt_next;
    status_t st_reg, st_next;
    logic ov_reg, ov_next;

    logic id_we, pr_we;
    logic [AW-1:0] waddr, raddr;
    logic [ID_W-1:0] id_wd, id_rd, pr_wd, pr_rd;
    logic [PAGES_W-1:0] pg_wd, pg_rd;
    logic [CW-1:0] mid;

    pts_ram #(.WIDTH(ID_W), .DEPTH(TABLE_DEPTH)) u_ids (
        .aclk(aclk), .we(id_we), .waddr(waddr), .wdata(id_wd), .raddr(raddr), .rdata(id_rd));
    pts_ram #(.WIDTH(ID_W), .DEPTH(TABLE_DEPTH)) u_par (
        .aclk(aclk), .we(pr_we), .waddr(waddr), .wdata(pr_wd), .raddr(raddr), .rdata(pr_rd));
    pts_ram #(.WIDTH(PAGES_W), .DEPTH(TABLE_DEPTH)) u_pg (
        .aclk(aclk), .we(pr_we), .waddr(waddr), .wdata(pg_wd), .raddr(raddr), .rdata(pg_rd));

    assign s_tready = (state_reg == S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata = {7'd0, st_reg, amt_reg};
    assign mid = CW'((CW+1)'(lo_reg) + (CW+1)'(hi_reg) >> 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            psize_reg <= PSIZE_RESET;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_valid && cfg_ready) begin
                psize_reg <= cfg_data;
            end
        end
        purp_reg <= purp_next; cmd_reg <= cmd_next; id_reg <= id_next;
        par_reg <= par_next; pg_reg <= pg_next; lo_reg <= lo_next; hi_reg <= hi_next;
        key_reg <= key_next; found_reg <= found_next; fidx_reg <= fidx_next;
        sh_reg <= sh_next; ent_reg <= ent_next; eidx_reg <= eidx_next;
        cur_reg <= cur_next; dep_reg <= dep_next; tot_reg <= tot_next;
        prod_reg <= prod_next; amt_reg <= amt_next; st_reg <= st_next; ov_reg <= ov_next;
    end

    always_comb begin
        logic [AMT_W:0] sum;
        state_next = state_reg; purp_next = purp_reg; count_next = count_reg;
        cmd_next = cmd_reg; id_next = id_reg; par_next = par_reg; pg_next = pg_reg;
        lo_next = lo_reg; hi_next = hi_reg; key_next = key_reg; found_next = found_reg;
        fidx_next = fidx_reg; sh_next = sh_reg; ent_next = ent_reg; eidx_next = eidx_reg;
        cur_next = cur_reg; dep_next = dep_reg; tot_next = tot_reg; prod_next = prod_reg;
        amt_next = amt_reg; st_next = st_reg; ov_next = ov_reg;
        id_we = 1'b0; pr_we = 1'b0; waddr = '0; raddr = mid[AW-1:0];
        id_wd = id_rd; pr_wd = pr_rd; pg_wd = pg_rd;
        sum = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd_next = cmd_t'(s_tdata[1:0]);
                    id_next = s_tdata[24:2];
                    par_next = s_tdata[47:25];
                    pg_next = s_tdata[75:48];
                    amt_next = '0;
                    st_next = ST_DONE;
                    lo_next = '0;
                    hi_next = count_reg;
                    key_next = s_tdata[24:2];
                    found_next = 1'b0;
                    if (cmd_t'(s_tdata[1:0]) == CMD_CLEAR) begin
                        count_next = '0;
                        state_next = S_OUT;
                    end else if (s_tdata[24:2] == '0) begin
                        st_next = ST_BADID;
                        state_next = S_OUT;
                    end else begin
                        purp_next = (cmd_t'(s_tdata[1:0]) == CMD_ADD) ? P_ADD : P_QRY;
                        state_next = S_SRD;
                    end
                end
            end
            // lower-bound search over [lo, hi)
            S_SRD: begin
                if (lo_reg >= hi_reg) begin
                    state_next = S_DECIDE;
                end else begin
                    state_next = S_SCMP;
                end
            end
            S_SCMP: begin
                if (id_rd < key_reg) begin
                    lo_next = mid + CW'(1);
                end else begin
                    hi_next = mid;
                    if (id_rd == key_reg) begin
                        found_next = 1'b1;
                        fidx_next = mid[AW-1:0];
                    end
                end
                state_next = S_SRD;
            end
            S_DECIDE: begin
                priority case (purp_reg)
                    P_ADD: begin
                        if (found_reg) begin
                            pr_we = 1'b1; waddr = fidx_reg;
                            pr_wd = par_reg; pg_wd = pg_reg;
                            state_next = S_OUT;
                        end else if (count_reg >= CW'(TABLE_DEPTH)) begin
                            st_next = ST_FULL;
                            state_next = S_OUT;
                        end else begin
                            sh_next = count_reg;
                            state_next = S_SHRD;
                        end
                    end
                    P_QRY: begin
                        if (!found_reg) begin
                            st_next = ST_MISS;
                            state_next = S_OUT;
                        end else if (cmd_reg == CMD_OWN) begin
                            raddr = fidx_reg;
                            state_next = S_OWNRD;
                        end else begin
                            ent_next = '0;
                            tot_next = '0;
                            state_next = S_TENT;
                        end
                    end
                    default: begin
                        // walk step: parent lookup result
                        if (!found_reg) begin
                            state_next = S_TENT;
                        end else begin
                            eidx_next = fidx_reg;
                            cur_next = key_reg;
                            dep_next = dep_reg + DW'(1);
                            state_next = S_TCHK;
                        end
                    end
                endcase
            end
            S_SHRD: begin
                if (sh_reg == lo_reg) begin
                    state_next = S_INS;
                end else begin
                    raddr = sh_reg[AW-1:0] - AW'(1);
                    state_next = S_SHWR;
                end
            end
            S_SHWR: begin
                id_we = 1'b1; pr_we = 1'b1; waddr = sh_reg[AW-1:0];
                sh_next = sh_reg - CW'(1);
                state_next = S_SHRD;
            end
            S_INS: begin
                id_we = 1'b1; pr_we = 1'b1; waddr = lo_reg[AW-1:0];
                id_wd = id_reg; pr_wd = par_reg; pg_wd = pg_reg;
                count_next = count_reg + CW'(1);
                state_next = S_OUT;
            end
            S_OWNRD: begin
                prod_next = (AMT_W+1)'(pg_rd) * (AMT_W+1)'(psize_reg);
                state_next = S_MUL;
            end
            S_MUL: begin
                amt_next = prod_reg[AMT_W] ? AMT_MAX : prod_reg[AMT_W-1:0];
                state_next = S_OUT;
            end
            S_TENT: begin
                if (ent_reg >= count_reg) begin
                    amt_next = tot_reg;
                    state_next = S_OUT;
                end else begin
                    raddr = ent_reg[AW-1:0];
                    eidx_next = ent_reg[AW-1:0];
                    dep_next = '0;
                    ent_next = ent_reg + CW'(1);
                    cur_next = '0;
                    state_next = S_TCHK;
                    ov_next = 1'b1;
                end
            end
            S_TCHK: begin
                raddr = eidx_reg;
                if (dep_reg >= DW'(MAX_CHAIN)) begin
                    state_next = S_TENT;
                end else begin
                    state_next = S_TPAR;
                end
            end
            S_TPAR: begin
                // id_rd/pr_rd hold entry at eidx; cur is id_rd on first step
                if ((ov_reg ? id_rd : cur_reg) == id_reg) begin
                    raddr = ent_reg[AW-1:0] - AW'(1);
                    state_next = S_TADD;
                end else if (pr_rd == '0) begin
                    state_next = S_TENT;
                end else begin
                    purp_next = P_WALK;
                    key_next = pr_rd;
                    lo_next = '0; hi_next = count_reg; found_next = 1'b0;
                    state_next = S_SRD;
                end
                ov_next = 1'b0;
            end
            S_TADD: begin
                prod_next = (AMT_W+1)'(pg_rd) * (AMT_W+1)'(psize_reg);
                state_next = S_TSUM;
            end
            S_TSUM: begin
                sum = (AMT_W+1)'(tot_reg) + prod_reg;
                tot_next = sum[AMT_W] ? AMT_MAX : sum[AMT_W-1:0];
                state_next = S_TENT;
            end
            S_OUT: begin
                if (m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    `ASSERT_CLK(a_cnt_max, aclk, aresetn, count_reg <= CW'(TABLE_DEPTH), "count overflow")
    `ASSERT_CLK(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result lost")
    `ASSERT_CLK(a_clr, aclk, aresetn, s_tvalid && s_tready && s_tdata[1:0] == CMD_CLEAR |=> count_reg == '0, "clear failed")
endmodule
